/* rtl/ndg_pkg.sv */
`timescale 1ns / 1ps

package ndg_pkg;

  // Depth limit after reset
  localparam logic [9:0] LIMIT_RESET = 10'd512;

  // Characters of interest
  localparam logic [7:0] CH_LPAREN = 8'h28;  // (
  localparam logic [7:0] CH_RPAREN = 8'h29;  // )
  localparam logic [7:0] CH_LBRACK = 8'h5B;  // [
  localparam logic [7:0] CH_RBRACK = 8'h5D;  // ]
  localparam logic [7:0] CH_LBRACE = 8'h7B;  // {
  localparam logic [7:0] CH_RBRACE = 8'h7D;  // }
  localparam logic [7:0] CH_CARET  = 8'h5E;  // ^
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // -
  localparam logic [7:0] CH_PLUS   = 8'h2B;  // +
  localparam logic [7:0] CH_STAR   = 8'h2A;  // *
  localparam logic [7:0] CH_SLASH  = 8'h2F;  // /
  localparam logic [7:0] CH_COMMA  = 8'h2C;  // ,
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [2:0] {
    CLS_OPEN,
    CLS_CLOSE,
    CLS_CARET,
    CLS_MINUS,
    CLS_SEP,
    CLS_SPACE,
    CLS_OPERAND
  } ndg_class_t;

  // Saved runs of one bracket level
  typedef struct packed {
    logic [9:0] minus;
    logic [9:0] caret;
  } ndg_runs_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ndg_stack_cmd_t;

  function automatic ndg_class_t ndg_classify(input logic [7:0] c);
    ndg_class_t cls;
    case (c) inside
      CH_LPAREN, CH_LBRACK, CH_LBRACE: cls = CLS_OPEN;
      CH_RPAREN, CH_RBRACK, CH_RBRACE: cls = CLS_CLOSE;
      CH_CARET:                        cls = CLS_CARET;
      CH_MINUS:                        cls = CLS_MINUS;
      CH_PLUS, CH_STAR, CH_SLASH, CH_COMMA: cls = CLS_SEP;
      CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: cls = CLS_SPACE;
      default:                         cls = CLS_OPERAND;
    endcase
    return cls;
  endfunction

endpackage

/* rtl/expression_nesting_depth_guard.sv */
`timescale 1ns / 1ps

// Channel  | Dir | Beat contents (lowest bit first)          | Accepted when
// ---------+-----+-------------------------------------------+----------------------
// in_      | in  | tdata: text_byte[7:0]; tlast: last_byte    | in_tvalid & in_tready
// out_     | out | tdata: status, error_position[15:0], pad  | out_tvalid & out_tready
//          |     | tlast: end_of_text                        |
// cfg_     | in  | cfg_data: depth_limit[9:0]                | cfg_valid & cfg_ready
//
// One beat per clock sustained while out_tready stays high. A byte is held in
// the input register, is scored there against the run counters and the stack
// (top held in a register, next entry prefetched from the stack memory) and
// lands in the output register. Output stalls back up through in_tready; the
// output register and input register each hold one beat.
// Reset is synchronous; the stack memory is not cleared, only its fill count.
module expression_nesting_depth_guard #(
  parameter int STACK_DEPTH   = 1024,
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // last_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] status, [16:1] error_position, [23:17] zero
  output logic        out_tlast,  // end_of_text
  // depth limit register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data
);
  import ndg_pkg::*;

  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  // configuration
  logic [9:0]               limit_r;

  // input register
  logic                     s1_valid_r;
  logic [7:0]               s1_byte_r;
  logic                     s1_last_r;

  // scan state
  logic [10:0]              enc_r, enc_nxt;
  logic [9:0]               minus_r, minus_nxt;
  logic [9:0]               caret_r, caret_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     err_r, err_nxt;
  logic [15:0]              err_idx_r, err_idx_nxt;

  // output register
  logic                     out_valid_r;
  logic                     out_status_r;
  logic [15:0]              out_pos_r;
  logic                     out_last_r;

  logic                     advance;
  logic                     fire;
  ndg_class_t               cls;
  ndg_stack_cmd_t           stk_cmd;
  ndg_runs_t                stk_top;
  ndg_runs_t                push_runs;
  logic [FW-1:0]            stk_fill;
  logic [47:0]              pos_wide;
  logic [15:0]              pos16;
  logic [11:0]              limit_ext;
  logic [11:0]              open_sum;
  logic [11:0]              caret_sum;
  logic [11:0]              minus_sum;
  logic [10:0]              caret_inc;
  logic [10:0]              minus_inc;
  logic [10:0]              drop;

  // the pipeline moves whenever the output register is free or being drained
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign fire      = s1_valid_r && advance;
  assign cfg_ready = 1'b1;

  assign cls       = ndg_classify(s1_byte_r);
  assign pos_wide  = 48'(pos_r);
  assign pos16     = pos_wide[15:0];
  assign limit_ext = 12'(limit_r);
  assign push_runs = '{minus: minus_r, caret: caret_r};

  // costs; the sums are one bit wider than the state so a breach compares true
  assign caret_inc = 11'(caret_r) + 11'd1;
  assign minus_inc = 11'(minus_r) + 11'd1;
  assign open_sum  = 12'(enc_r) + 12'(minus_r) + 12'(caret_r) + 12'd1;
  assign caret_sum = 12'(enc_r) + 12'(minus_r) + 12'(caret_inc);
  assign minus_sum = 12'(enc_r) + 12'(minus_inc);
  assign drop      = 11'(stk_top.minus) + 11'(stk_top.caret) + 11'd1;

  always_comb begin
    enc_nxt       = enc_r;
    minus_nxt     = minus_r;
    caret_nxt     = caret_r;
    err_nxt       = err_r;
    err_idx_nxt   = err_idx_r;
    pos_nxt       = (pos_r == POS_MAX) ? pos_r : pos_r + POSITION_BITS'(1);
    stk_cmd.push  = 1'b0;
    stk_cmd.pop   = 1'b0;
    stk_cmd.clear = 1'b0;

    // after a breach the text only advances the position count
    if (!err_r) begin
      case (cls)
        CLS_OPEN: begin
          if (stk_fill == FW'(STACK_DEPTH)) begin
            err_nxt = 1'b1;
          end else begin
            stk_cmd.push = fire;
            enc_nxt      = open_sum[10:0];
            minus_nxt    = '0;
            caret_nxt    = '0;
            err_nxt      = (open_sum > limit_ext);
          end
        end
        CLS_CLOSE: begin
          // unmatched close is dropped
          if (stk_fill != '0) begin
            stk_cmd.pop = fire;
            enc_nxt     = (enc_r >= drop) ? enc_r - drop : '0;
            minus_nxt   = '0;
            caret_nxt   = stk_top.caret;
          end
        end
        CLS_CARET: begin
          caret_nxt = caret_inc[9:0];
          err_nxt   = (caret_sum > limit_ext);
        end
        CLS_MINUS: begin
          caret_nxt = '0;
          minus_nxt = minus_inc[9:0];
          err_nxt   = (minus_sum > limit_ext);
        end
        CLS_SEP: begin
          minus_nxt = '0;
          caret_nxt = '0;
        end
        CLS_SPACE: begin
        end
        default: begin
          minus_nxt = '0;
        end
      endcase
      if (err_nxt) begin
        err_idx_nxt = pos16;
      end
    end

    if (s1_last_r) begin
      stk_cmd.clear = fire;
    end
  end

  ndg_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (stk_cmd),
    .push_data (push_runs),
    .top       (stk_top),
    .fill      (stk_fill)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      enc_r       <= '0;
      minus_r     <= '0;
      caret_r     <= '0;
      pos_r       <= '0;
      err_r       <= 1'b0;
      err_idx_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (fire) begin
        if (s1_last_r) begin
          // end of text: everything but the limit starts over
          enc_r     <= '0;
          minus_r   <= '0;
          caret_r   <= '0;
          pos_r     <= '0;
          err_r     <= 1'b0;
          err_idx_r <= '0;
        end else begin
          enc_r     <= enc_nxt;
          minus_r   <= minus_nxt;
          caret_r   <= caret_nxt;
          pos_r     <= pos_nxt;
          err_r     <= err_nxt;
          err_idx_r <= err_idx_nxt;
        end
      end
    end
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (fire) begin
      out_status_r <= err_nxt;
      out_pos_r    <= err_nxt ? err_idx_nxt : 16'd0;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_pos_r, out_status_r};
  assign out_tlast  = out_last_r;

endmodule

/* rtl/ndg_stack.sv */
`timescale 1ns / 1ps

// Bracket stack. Top entry lives in a register; the rest sits in a memory
// whose registered read port always prefetches the entry below the top.
module ndg_stack #(
  parameter int STACK_DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ndg_pkg::ndg_stack_cmd_t            cmd,
  input  ndg_pkg::ndg_runs_t                 push_data,
  output ndg_pkg::ndg_runs_t                 top,
  output logic [$clog2(STACK_DEPTH+1)-1:0]   fill
);
  import ndg_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int FW = $clog2(STACK_DEPTH + 1);

  ndg_runs_t       mem [STACK_DEPTH];

  logic [FW-1:0]   fill_r, fill_nxt;
  ndg_runs_t       top_r, top_nxt;
  ndg_runs_t       rd_q_r;
  logic            byp_r, byp_nxt;
  ndg_runs_t       byp_data_r;
  ndg_runs_t       below;
  logic            wr_en;
  logic [FW-1:0]   wr_fill;
  logic [FW-1:0]   rd_fill;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr;

  // a push writes the address that is read in the same cycle: forward it
  assign below = byp_r ? byp_data_r : rd_q_r;

  always_comb begin
    fill_nxt = fill_r;
    top_nxt  = top_r;
    wr_en    = 1'b0;
    if (cmd.clear) begin
      fill_nxt = '0;
    end else if (cmd.push) begin
      fill_nxt = fill_r + FW'(1);
      top_nxt  = push_data;
      wr_en    = (fill_r != '0);
    end else if (cmd.pop) begin
      fill_nxt = fill_r - FW'(1);
      top_nxt  = below;
    end
    byp_nxt = wr_en;
  end

  assign wr_fill = fill_r - FW'(1);
  assign rd_fill = fill_nxt - FW'(2);
  assign wr_addr = wr_fill[AW-1:0];
  assign rd_addr = rd_fill[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= top_r;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      byp_r  <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      byp_r  <= byp_nxt;
    end
    top_r      <= top_nxt;
    byp_data_r <= top_r;
  end

  assign top  = top_r;
  assign fill = fill_r;

endmodule
